@@ design/bbpe_pkg.sv @@
// Package with the word types and fixed-point constants of the Bezier patch evaluator.
`default_nettype none
package bbpe_pkg;

  // Command codes carried in the cmd field of an input word.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Parameter value that stands for 1.0 in unsigned Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Bit at which a rescaled vector keeps its largest magnitude.
  localparam int NORM_MSB = 29;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [16:0]        u_param;
    logic [16:0]        v_param;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_word_t;

endpackage
`default_nettype wire

@@ design/bbpe_in_if.sv @@
// Valid/ready channel that carries command words into the evaluator.
`default_nettype none
interface bbpe_in_if;
  logic               valid;
  logic               ready;
  bbpe_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/bbpe_out_if.sv @@
// Valid/ready channel that carries evaluated surface words out of the evaluator.
`default_nettype none
interface bbpe_out_if;
  logic                valid;
  logic                ready;
  bbpe_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/bicubic_bezier_patch_evaluator_core.sv @@
// Top level of the bicubic Bezier patch evaluator: a 65-stage fixed-point pipeline.
`default_nettype none
// The block holds the 16 control points of one bicubic Bezier patch in registers
// (cleared to zero by reset) and evaluates the patch at (u, v). A load word writes one
// control point and returns nothing; an evaluate word returns the surface point and the
// unit normal with a degenerate flag. The pipeline takes one word in every cycle. Its depth
// is set by the square root of the normal length (one root bit per stage, 31 stages) and
// the division of each normal component by that length (one quotient bit per stage, 15
// stages). All stages advance together: while the output word waits for ready, the whole
// pipeline holds and input ready is low; otherwise a word is taken every cycle. A load
// takes effect in the third stage, so an evaluate word always sees exactly the loads that
// were accepted before it.
module bicubic_bezier_patch_evaluator_core #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  bbpe_in_if.sink   inp,
  bbpe_out_if.source outp
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = 34;          // derivative weight, signed Q3.30
  localparam int RW   = CW + 2;      // row sum of plain weights
  localparam int RDW  = CW + 4;      // row sum of derivative weights
  localparam int TW   = CW + 5;      // position and tangent sums
  localparam int WIDE = CW + 36;     // raw product before rounding
  localparam int REMW = 36;          // square root remainder
  localparam int SQN  = 31;          // root bits
  localparam int QN   = 15;          // quotient bits
  localparam int NW   = 46;          // division numerator
  localparam int SQ0  = 17;          // stage that holds the sum of squares
  localparam int DV0  = SQ0 + SQN + 1;
  localparam int NST  = DV0 + QN + 1;

  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

  // Saturates a value to the signed COORD_WIDTH-bit range.
  function automatic logic signed [63:0] sat_cw(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = x;
    if (x > CMAX) r = CMAX;
    if (x < CMIN) r = CMIN;
    return r;
  endfunction

  // Divides by 2^30 with rounding half away from zero.
  function automatic logic signed [WIDE-1:0] rnd30(input logic signed [WIDE-1:0] p);
    logic [WIDE-1:0] m;
    logic [WIDE-1:0] r;
    m = p[WIDE-1] ? WIDE'(-p) : WIDE'(p);
    r = (m + (WIDE'(1) << 29)) >> 30;
    return p[WIDE-1] ? -$signed(r) : $signed(r);
  endfunction

  // Bernstein weight from a product of two factors and one more factor, rounded to Q0.30.
  function automatic logic [30:0] bern(input logic [33:0] p2, input logic [16:0] f,
                                       input logic triple);
    logic [52:0] prod;
    prod = 53'(p2) * 53'(f);
    if (triple) prod = prod + (prod << 1);
    return 31'((prod + (53'(1) << 17)) >> 18);
  endfunction

  // Derivative weight j, divided by four with rounding half away from zero.
  function automatic logic signed [DW-1:0] dwt(input logic [33:0] ss, input logic [33:0] ts,
                                               input logic [33:0] tt, input logic [1:0] j);
    logic signed [37:0] a;
    logic signed [37:0] b;
    logic signed [37:0] c;
    logic signed [37:0] x;
    logic [37:0]        m;
    logic [37:0]        r;
    a = $signed(38'(ss)) * 38'sd3;
    b = $signed(38'(ts)) * 38'sd6;
    c = $signed(38'(tt)) * 38'sd3;
    case (j)
      2'd0:    x = -a;
      2'd1:    x = a - b;
      2'd2:    x = b - c;
      default: x = c;
    endcase
    m = x[37] ? 38'(-x) : 38'(x);
    r = (m + 38'd2) >> 2;
    return x[37] ? -DW'($signed(r)) : DW'($signed(r));
  endfunction

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [5:0] msb64(input logic [63:0] x);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Shifts a magnitude so that bit p lands on the normalizing bit.
  function automatic logic [29:0] normsh(input logic [63:0] m, input logic [5:0] p);
    logic [63:0] r;
    if (p >= 6'(bbpe_pkg::NORM_MSB)) r = m >> (p - 6'(bbpe_pkg::NORM_MSB));
    else r = m << (6'(bbpe_pkg::NORM_MSB) - p);
    return r[29:0];
  endfunction

  // Pipeline control. A single advance moves every stage.
  logic [NST:1] vld;
  logic         adv;
  logic         accept;

  assign adv       = !vld[NST] || outp.ready;
  assign inp.ready = adv;
  assign accept    = inp.valid && adv;

  // Control point store, slot = row * 4 + column.
  logic signed [CW-1:0] cp [16][3];

  // Stage 1: captured word, clamped parameters and their complements.
  logic                 a_eval;
  logic [3:0]           a_idx;
  logic signed [CW-1:0] a_c [3];
  logic [16:0]          a_tu, a_su, a_tv, a_sv;

  // Stage 2: squares and cross terms of the parameters.
  logic                 b_eval;
  logic [3:0]           b_idx;
  logic signed [CW-1:0] b_c [3];
  logic [16:0]          b_tu, b_su, b_tv, b_sv;
  logic [33:0]          b_ssu, b_tsu, b_ttu, b_ssv, b_tsv, b_ttv;

  // Stage 3: Bernstein weights and derivative weights.
  logic                 c_eval;
  logic [3:0]           c_idx;
  logic signed [CW-1:0] c_c [3];
  logic [30:0]          c_bu [4];
  logic [30:0]          c_bv [4];
  logic signed [DW-1:0] c_du [4];
  logic signed [DW-1:0] c_dv [4];

  // Stage 4: raw control point products.
  logic signed [WIDE-1:0] d_pb [3][4][4];
  logic signed [WIDE-1:0] d_pd [3][4][4];
  logic [30:0]            d_bv [4];
  logic signed [DW-1:0]   d_dv [4];

  // Stage 5: row sums.
  logic signed [RW-1:0]  e_row  [3][4];
  logic signed [RDW-1:0] e_rowd [3][4];
  logic [30:0]           e_bv [4];
  logic signed [DW-1:0]  e_dv [4];

  // Stage 6: raw row products.
  logic signed [WIDE-1:0] f_p [3][4];
  logic signed [WIDE-1:0] f_u [3][4];
  logic signed [WIDE-1:0] f_v [3][4];

  // Stage 7: position and the two tangents.
  logic signed [TW-1:0] g_pos [3];
  logic signed [TW-1:0] g_tu  [3];
  logic signed [TW-1:0] g_tv  [3];

  // Stage 8: saturated position, tangent magnitudes and signs.
  logic [31:0]   h_pos [3];
  logic [TW-1:0] h_um [3];
  logic [TW-1:0] h_vm [3];
  logic [2:0]    h_us, h_vs;

  // Stage 9: normalizing shift of each tangent.
  logic [31:0]   i_pos [3];
  logic [TW-1:0] i_um [3];
  logic [TW-1:0] i_vm [3];
  logic [2:0]    i_us, i_vs;
  logic [5:0]    i_pu, i_pv;

  // Stage 10: rescaled tangents.
  logic [31:0]        j_pos [3];
  logic signed [30:0] j_u [3];
  logic signed [30:0] j_v [3];

  // Stage 11: cross product terms.
  logic [31:0]        k_pos [3];
  logic signed [61:0] k_a [3];
  logic signed [61:0] k_b [3];

  // Stage 12: cross product.
  logic [31:0]        l_pos [3];
  logic signed [62:0] l_cr [3];

  // Stage 13: cross product magnitudes, signs and the zero test.
  logic [31:0] m_pos [3];
  logic [61:0] m_cm [3];
  logic [2:0]  m_cs;
  logic        m_dg;

  // Stage 14: normalizing shift of the cross product.
  logic [31:0] n_pos [3];
  logic [61:0] n_cm [3];
  logic [2:0]  n_cs;
  logic        n_dg;
  logic [5:0]  n_p;

  // Stage 15: rescaled cross product magnitudes.
  logic [31:0] o_pos [3];
  logic [29:0] o_nm [3];
  logic [2:0]  o_cs;
  logic        o_dg;

  // Stage 16: squares.
  logic [31:0] p_pos [3];
  logic [29:0] p_nm [3];
  logic [2:0]  p_cs;
  logic        p_dg;
  logic [59:0] p_sq [3];

  // Square root stages; entry 0 holds the sum of squares.
  logic [61:0]     sr_x    [SQN+1];
  logic [SQN-1:0]  sr_root [SQN+1];
  logic [REMW-1:0] sr_rem  [SQN+1];
  logic [31:0]     sr_pos  [SQN+1][3];
  logic [29:0]     sr_nm   [SQN+1][3];
  logic [2:0]      sr_cs   [SQN+1];
  logic            sr_dg   [SQN+1];
  logic [SQN-1:0]  sr_root_next [1:SQN];
  logic [REMW-1:0] sr_rem_next  [1:SQN];

  // Division stages; entry 0 holds the numerators.
  logic [SQN-1:0] dv_len [QN+1];
  logic [NW-1:0]  dv_rem [QN+1][3];
  logic [QN-1:0]  dv_q   [QN+1][3];
  logic [31:0]    dv_pos [QN+1][3];
  logic [2:0]     dv_cs  [QN+1];
  logic           dv_dg  [QN+1];
  logic [NW-1:0]  dv_rem_next [1:QN][3];
  logic [QN-1:0]  dv_q_next   [1:QN][3];

  // Output word.
  bbpe_pkg::out_word_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld[1] <= accept;
      vld[2] <= vld[1];
      vld[3] <= vld[2];
      // Loads end at the store; only evaluate words go on.
      vld[4] <= vld[3] && (c_eval == bbpe_pkg::CMD_EVAL);
      for (int s = 5; s <= NST; s++) vld[s] <= vld[s-1];
    end
  end

  // The store is written when a load word leaves stage 3, in order with evaluate words.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 16; n++) begin
        for (int k = 0; k < 3; k++) cp[n][k] <= '0;
      end
    end else if (adv && vld[3] && (c_eval == bbpe_pkg::CMD_LOAD)) begin
      for (int k = 0; k < 3; k++) cp[c_idx][k] <= c_c[k];
    end
  end

  // Weight front end, stages 1 to 3.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_eval <= inp.data.cmd;
      a_idx  <= inp.data.point_index;
      a_c[0] <= CW'(sat_cw(64'(inp.data.coord_x)));
      a_c[1] <= CW'(sat_cw(64'(inp.data.coord_y)));
      a_c[2] <= CW'(sat_cw(64'(inp.data.coord_z)));
      if (inp.data.u_param > bbpe_pkg::ONE_Q16) begin
        a_tu <= bbpe_pkg::ONE_Q16;
        a_su <= '0;
      end else begin
        a_tu <= inp.data.u_param;
        a_su <= bbpe_pkg::ONE_Q16 - inp.data.u_param;
      end
      if (inp.data.v_param > bbpe_pkg::ONE_Q16) begin
        a_tv <= bbpe_pkg::ONE_Q16;
        a_sv <= '0;
      end else begin
        a_tv <= inp.data.v_param;
        a_sv <= bbpe_pkg::ONE_Q16 - inp.data.v_param;
      end

      b_eval <= a_eval;
      b_idx  <= a_idx;
      b_c    <= a_c;
      b_tu   <= a_tu;
      b_su   <= a_su;
      b_tv   <= a_tv;
      b_sv   <= a_sv;
      b_ssu  <= 34'(a_su) * 34'(a_su);
      b_tsu  <= 34'(a_tu) * 34'(a_su);
      b_ttu  <= 34'(a_tu) * 34'(a_tu);
      b_ssv  <= 34'(a_sv) * 34'(a_sv);
      b_tsv  <= 34'(a_tv) * 34'(a_sv);
      b_ttv  <= 34'(a_tv) * 34'(a_tv);

      c_eval  <= b_eval;
      c_idx   <= b_idx;
      c_c     <= b_c;
      c_bu[0] <= bern(b_ssu, b_su, 1'b0);
      c_bu[1] <= bern(b_tsu, b_su, 1'b1);
      c_bu[2] <= bern(b_ttu, b_su, 1'b1);
      c_bu[3] <= bern(b_ttu, b_tu, 1'b0);
      c_bv[0] <= bern(b_ssv, b_sv, 1'b0);
      c_bv[1] <= bern(b_tsv, b_sv, 1'b1);
      c_bv[2] <= bern(b_ttv, b_sv, 1'b1);
      c_bv[3] <= bern(b_ttv, b_tv, 1'b0);
      for (int j = 0; j < 4; j++) begin
        c_du[j] <= dwt(b_ssu, b_tsu, b_ttu, 2'(j));
        c_dv[j] <= dwt(b_ssv, b_tsv, b_ttv, 2'(j));
      end
    end
  end

  // Patch sums, stages 4 to 7: rows along u first, then the columns along v.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            d_pb[k][r][c] <= WIDE'(cp[r*4+c][k]) * WIDE'($signed({1'b0, c_bu[c]}));
            d_pd[k][r][c] <= WIDE'(cp[r*4+c][k]) * WIDE'(c_du[c]);
          end
        end
      end
      d_bv <= c_bv;
      d_dv <= c_dv;

      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 4; r++) begin
          e_row[k][r]  <= RW'(rnd30(d_pb[k][r][0])) + RW'(rnd30(d_pb[k][r][1]))
                        + RW'(rnd30(d_pb[k][r][2])) + RW'(rnd30(d_pb[k][r][3]));
          e_rowd[k][r] <= RDW'(rnd30(d_pd[k][r][0])) + RDW'(rnd30(d_pd[k][r][1]))
                        + RDW'(rnd30(d_pd[k][r][2])) + RDW'(rnd30(d_pd[k][r][3]));
        end
      end
      e_bv <= d_bv;
      e_dv <= d_dv;

      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 4; r++) begin
          f_p[k][r] <= WIDE'(e_row[k][r]) * WIDE'($signed({1'b0, e_bv[r]}));
          f_u[k][r] <= WIDE'(e_rowd[k][r]) * WIDE'($signed({1'b0, e_bv[r]}));
          f_v[k][r] <= WIDE'(e_row[k][r]) * WIDE'(e_dv[r]);
        end
      end

      for (int k = 0; k < 3; k++) begin
        g_pos[k] <= TW'(rnd30(f_p[k][0])) + TW'(rnd30(f_p[k][1]))
                  + TW'(rnd30(f_p[k][2])) + TW'(rnd30(f_p[k][3]));
        g_tu[k]  <= TW'(rnd30(f_u[k][0])) + TW'(rnd30(f_u[k][1]))
                  + TW'(rnd30(f_u[k][2])) + TW'(rnd30(f_u[k][3]));
        g_tv[k]  <= TW'(rnd30(f_v[k][0])) + TW'(rnd30(f_v[k][1]))
                  + TW'(rnd30(f_v[k][2])) + TW'(rnd30(f_v[k][3]));
      end
    end
  end

  // Tangent rescaling, the cross product, its rescaling and the squares, stages 8 to 16.
  always_ff @(posedge clk) begin
    logic signed [63:0] psat;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        psat     = sat_cw(64'(g_pos[k]));
        h_pos[k] <= psat[31:0];
        h_um[k]  <= g_tu[k][TW-1] ? TW'(-g_tu[k]) : TW'(g_tu[k]);
        h_vm[k]  <= g_tv[k][TW-1] ? TW'(-g_tv[k]) : TW'(g_tv[k]);
        h_us[k]  <= g_tu[k][TW-1];
        h_vs[k]  <= g_tv[k][TW-1];
      end

      i_pos <= h_pos;
      i_um  <= h_um;
      i_vm  <= h_vm;
      i_us  <= h_us;
      i_vs  <= h_vs;
      // The highest bit of the OR of the magnitudes is the highest bit of the largest one.
      i_pu  <= msb64(64'(h_um[0] | h_um[1] | h_um[2]));
      i_pv  <= msb64(64'(h_vm[0] | h_vm[1] | h_vm[2]));

      j_pos <= i_pos;
      for (int k = 0; k < 3; k++) begin
        j_u[k] <= i_us[k] ? -$signed(31'(normsh(64'(i_um[k]), i_pu)))
                          : $signed(31'(normsh(64'(i_um[k]), i_pu)));
        j_v[k] <= i_vs[k] ? -$signed(31'(normsh(64'(i_vm[k]), i_pv)))
                          : $signed(31'(normsh(64'(i_vm[k]), i_pv)));
      end

      k_pos  <= j_pos;
      k_a[0] <= 62'(j_u[1]) * 62'(j_v[2]);
      k_b[0] <= 62'(j_u[2]) * 62'(j_v[1]);
      k_a[1] <= 62'(j_u[2]) * 62'(j_v[0]);
      k_b[1] <= 62'(j_u[0]) * 62'(j_v[2]);
      k_a[2] <= 62'(j_u[0]) * 62'(j_v[1]);
      k_b[2] <= 62'(j_u[1]) * 62'(j_v[0]);

      l_pos <= k_pos;
      for (int k = 0; k < 3; k++) l_cr[k] <= 63'(k_a[k]) - 63'(k_b[k]);

      m_pos <= l_pos;
      for (int k = 0; k < 3; k++) begin
        m_cm[k] <= l_cr[k][62] ? 62'(-l_cr[k]) : 62'(l_cr[k]);
        m_cs[k] <= l_cr[k][62];
      end
      m_dg <= (l_cr[0] == '0) && (l_cr[1] == '0) && (l_cr[2] == '0);

      n_pos <= m_pos;
      n_cm  <= m_cm;
      n_cs  <= m_cs;
      n_dg  <= m_dg;
      n_p   <= msb64(64'(m_cm[0] | m_cm[1] | m_cm[2]));

      o_pos <= n_pos;
      o_cs  <= n_cs;
      o_dg  <= n_dg;
      for (int k = 0; k < 3; k++) o_nm[k] <= normsh(64'(n_cm[k]), n_p);

      p_pos <= o_pos;
      p_nm  <= o_nm;
      p_cs  <= o_cs;
      p_dg  <= o_dg;
      for (int k = 0; k < 3; k++) p_sq[k] <= 60'(o_nm[k]) * 60'(o_nm[k]);
    end
  end

  // One root bit per stage, taking two bits of the radicand each time.
  always_comb begin
    logic [REMW-1:0] trial;
    logic [REMW-1:0] sub;
    for (int i = 1; i <= SQN; i++) begin
      trial = (sr_rem[i-1] << 2) | REMW'(sr_x[i-1][2*(SQN-i) +: 2]);
      sub   = (REMW'(sr_root[i-1]) << 2) | REMW'(1);
      if (trial >= sub) begin
        sr_rem_next[i]  = trial - sub;
        sr_root_next[i] = (sr_root[i-1] << 1) | SQN'(1);
      end else begin
        sr_rem_next[i]  = trial;
        sr_root_next[i] = sr_root[i-1] << 1;
      end
    end
  end

  // One quotient bit per stage against the length shifted to that bit.
  always_comb begin
    logic [NW-1:0] dsh;
    for (int j = 1; j <= QN; j++) begin
      dsh = NW'(dv_len[j-1]) << (QN - j);
      for (int k = 0; k < 3; k++) begin
        if (dv_rem[j-1][k] >= dsh) begin
          dv_rem_next[j][k] = dv_rem[j-1][k] - dsh;
          dv_q_next[j][k]   = dv_q[j-1][k] | (QN'(1) << (QN - j));
        end else begin
          dv_rem_next[j][k] = dv_rem[j-1][k];
          dv_q_next[j][k]   = dv_q[j-1][k];
        end
      end
    end
  end

  // Length and normal division, stages 17 to 65.
  always_ff @(posedge clk) begin
    if (adv) begin
      sr_x[0]    <= 62'(p_sq[0]) + 62'(p_sq[1]) + 62'(p_sq[2]);
      sr_root[0] <= '0;
      sr_rem[0]  <= '0;
      sr_pos[0]  <= p_pos;
      sr_nm[0]   <= p_nm;
      sr_cs[0]   <= p_cs;
      sr_dg[0]   <= p_dg;
      for (int i = 1; i <= SQN; i++) begin
        sr_x[i]    <= sr_x[i-1];
        sr_root[i] <= sr_root_next[i];
        sr_rem[i]  <= sr_rem_next[i];
        sr_pos[i]  <= sr_pos[i-1];
        sr_nm[i]   <= sr_nm[i-1];
        sr_cs[i]   <= sr_cs[i-1];
        sr_dg[i]   <= sr_dg[i-1];
      end

      // The numerator carries half the length so that truncation rounds to nearest.
      dv_len[0] <= sr_root[SQN];
      dv_pos[0] <= sr_pos[SQN];
      dv_cs[0]  <= sr_cs[SQN];
      dv_dg[0]  <= sr_dg[SQN];
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= (NW'(sr_nm[SQN][k]) << 14) + NW'(sr_root[SQN] >> 1);
        dv_q[0][k]   <= '0;
      end
      for (int j = 1; j <= QN; j++) begin
        dv_len[j] <= dv_len[j-1];
        dv_pos[j] <= dv_pos[j-1];
        dv_cs[j]  <= dv_cs[j-1];
        dv_dg[j]  <= dv_dg[j-1];
        dv_rem[j] <= dv_rem_next[j];
        dv_q[j]   <= dv_q_next[j];
      end

      // A zero cross product gives a zero normal; the position still holds.
      out_word.pos_x      <= dv_pos[QN][0];
      out_word.pos_y      <= dv_pos[QN][1];
      out_word.pos_z      <= dv_pos[QN][2];
      out_word.degenerate <= dv_dg[QN];
      if (dv_dg[QN]) begin
        out_word.normal_x <= '0;
        out_word.normal_y <= '0;
        out_word.normal_z <= '0;
      end else begin
        out_word.normal_x <= dv_cs[QN][0] ? -$signed(16'(dv_q[QN][0]))
                                          : $signed(16'(dv_q[QN][0]));
        out_word.normal_y <= dv_cs[QN][1] ? -$signed(16'(dv_q[QN][1]))
                                          : $signed(16'(dv_q[QN][1]));
        out_word.normal_z <= dv_cs[QN][2] ? -$signed(16'(dv_q[QN][2]))
                                          : $signed(16'(dv_q[QN][2]));
      end
    end
  end

  assign outp.valid = vld[NST];
  assign outp.data  = out_word;

endmodule
`default_nettype wire
